// ===== src/brd_pkg.sv =====
// ----------------------------------------------------------------------------
// brd_pkg
// Types, constants and helper functions shared by the radix digit converter.
// ----------------------------------------------------------------------------
package brd_pkg;

    localparam int RadixW      = 5;
    localparam int ValueW      = 64;
    localparam int MinDigitsW  = 7;
    localparam int CharW       = 7;
    localparam int RemW        = 4;
    localparam int BitsPerCyc  = 8;
    localparam int MaxDigits   = 64;

    localparam logic [RadixW-1:0] RadixReset = 5'd10;
    localparam logic [RadixW-1:0] RadixMin   = 5'd2;
    localparam logic [RadixW-1:0] RadixMax   = 5'd16;

    // register indexes on the configuration port
    localparam logic RegRadix = 1'b0;

    // controller to datapath commands
    typedef struct packed {
        logic load;   // take a new value and padding count
        logic step;   // run one slice of the shared divider
        logic emit;   // move the finished digit to the output register
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic last;   // the digit now finished is the final one of its value
    } dp_status_t;

    // clamp the base register into 2..16
    function automatic logic [RadixW-1:0] eff_radix(input logic [RadixW-1:0] r);
        logic [RadixW-1:0] b;
        b = r;
        if (r < RadixMin) begin
            b = RadixMin;
        end else if (r > RadixMax) begin
            b = RadixMax;
        end
        return b;
    endfunction

    // digit value to lower-case ASCII character
    function automatic logic [CharW-1:0] digit_char(input logic [RemW-1:0] d);
        logic [CharW-1:0] c;
        if (d < 4'd10) begin
            c = 7'h30 + CharW'(d);
        end else begin
            c = 7'h61 + CharW'(d - 4'd10);
        end
        return c;
    endfunction

endpackage

// ===== src/brd_ctrl.sv =====
// ----------------------------------------------------------------------------
// brd_ctrl
// Sequencer for the radix digit converter: accepts a value, runs the divider
// slices for each digit and hands finished digits to the output register.
// ----------------------------------------------------------------------------
module brd_ctrl #(
    parameter int VALUE_BITS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output brd_pkg::dp_cmd_t    cmd,
    input  brd_pkg::dp_status_t status
);

    localparam int NumCyc = (VALUE_BITS + brd_pkg::BitsPerCyc - 1) / brd_pkg::BitsPerCyc;
    localparam int CntW   = (NumCyc > 1) ? $clog2(NumCyc) : 1;
    localparam logic [CntW-1:0] CntLast = CntW'(NumCyc - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]      state_reg, state_next;
    logic [CntW-1:0] slice_reg, slice_next;
    logic            m_valid_reg, m_valid_next;
    logic            out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        slice_next   = slice_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    slice_next = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.step = 1'b1;
                if (slice_reg == CntLast) begin
                    state_next = ST_DONE;
                end else begin
                    slice_next = slice_reg + 1'b1;
                end
            end
            ST_DONE: begin
                // hold the digit until the output register frees up
                if (out_free) begin
                    cmd.emit     = 1'b1;
                    m_valid_next = 1'b1;
                    slice_next   = '0;
                    state_next   = status.last ? ST_IDLE : ST_DIV;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            slice_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            slice_reg   <= slice_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== src/brd_dpath.sv =====
// ----------------------------------------------------------------------------
// brd_dpath
// Datapath of the radix digit converter: shift-and-subtract divider by the
// base, padding and digit counters, and the output digit register.
// ----------------------------------------------------------------------------
module brd_dpath #(
    parameter int VALUE_BITS = 64
) (
    input  logic                                  aclk,
    input  brd_pkg::dp_cmd_t                      cmd,
    output brd_pkg::dp_status_t                   status,
    input  logic [brd_pkg::RadixW-1:0]            radix,
    input  logic [brd_pkg::ValueW-1:0]            value_in,
    input  logic [brd_pkg::MinDigitsW-1:0]        min_digits_in,
    output logic [brd_pkg::CharW-1:0]             digit_char_out,
    output logic                                  last_out
);

    localparam int NumCyc = (VALUE_BITS + brd_pkg::BitsPerCyc - 1) / brd_pkg::BitsPerCyc;
    localparam int DivW   = NumCyc * brd_pkg::BitsPerCyc;
    localparam logic [brd_pkg::MinDigitsW-1:0] PadMax =
        brd_pkg::MinDigitsW'(brd_pkg::MaxDigits);

    logic [DivW-1:0]                 work_reg, work_next;
    logic [brd_pkg::RemW-1:0]        rem_reg, rem_next;
    logic [brd_pkg::MinDigitsW-1:0]  pad_reg, pad_next;
    logic [brd_pkg::MinDigitsW-1:0]  cnt_reg, cnt_next;
    logic [brd_pkg::CharW-1:0]       digit_reg, digit_next;
    logic                            last_reg, last_next;
    logic [brd_pkg::RadixW-1:0]      base;
    logic [brd_pkg::MinDigitsW-1:0]  pad_dec;
    logic [brd_pkg::MinDigitsW-1:0]  cnt_inc;
    logic [DivW-1:0]                 slice_work;
    logic [brd_pkg::RemW-1:0]        slice_rem;
    logic                            more;

    assign base    = brd_pkg::eff_radix(radix);
    assign pad_dec = (pad_reg != '0) ? pad_reg - 1'b1 : pad_reg;
    assign cnt_inc = cnt_reg + 1'b1;
    assign more    = ((work_reg != '0) || (pad_dec != '0)) && (cnt_inc < PadMax);
    assign status.last = !more;

    // one slice of restoring division: eight quotient bits per cycle
    always_comb begin
        logic [brd_pkg::RadixW-1:0] trial;
        logic                       ge;
        slice_work = work_reg;
        slice_rem  = rem_reg;
        for (int i = 0; i < brd_pkg::BitsPerCyc; i++) begin
            trial      = {slice_rem, slice_work[DivW-1]};
            ge         = (trial >= base);
            slice_rem  = ge ? brd_pkg::RemW'(trial - base) : trial[brd_pkg::RemW-1:0];
            slice_work = {slice_work[DivW-2:0], ge};
        end
    end

    always_comb begin
        work_next  = work_reg;
        rem_next   = rem_reg;
        pad_next   = pad_reg;
        cnt_next   = cnt_reg;
        digit_next = digit_reg;
        last_next  = last_reg;
        if (cmd.load) begin
            work_next = DivW'(value_in[VALUE_BITS-1:0]);
            rem_next  = '0;
            pad_next  = (min_digits_in > PadMax) ? PadMax : min_digits_in;
            cnt_next  = '0;
        end else if (cmd.step) begin
            work_next = slice_work;
            rem_next  = slice_rem;
        end else if (cmd.emit) begin
            // quotient stays in place as the next dividend
            digit_next = brd_pkg::digit_char(rem_reg);
            last_next  = !more;
            rem_next   = '0;
            pad_next   = pad_dec;
            cnt_next   = cnt_inc;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg  <= work_next;
        rem_reg   <= rem_next;
        pad_reg   <= pad_next;
        cnt_reg   <= cnt_next;
        digit_reg <= digit_next;
        last_reg  <= last_next;
    end

    assign digit_char_out = digit_reg;
    assign last_out       = last_reg;

endmodule

// ===== src/binary_to_radix_digits.sv =====
// ----------------------------------------------------------------------------
// binary_to_radix_digits
// Converts an unsigned value into lower-case ASCII digits in base 2..16.
// ----------------------------------------------------------------------------
// A value enters on the s_ stream together with a minimum digit count; its
// digits leave on the m_ stream one word each, least significant first, with
// tlast on the final digit. At least one digit is sent, and zeros pad the
// output up to the minimum count (capped at 64). The base comes from the radix
// register (reset 10; settings below 2 act as 2, above 16 as 16). For each
// digit the shared shift-and-subtract divider retires eight quotient bits per
// cycle, and the digit then moves to the output register once that register
// is free. The next value is taken as soon as the final digit sits in the
// output register.
// ----------------------------------------------------------------------------
module binary_to_radix_digits #(
    parameter int VALUE_BITS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // value stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [63:0] value, [70:64] min_digits, [71] zero
    // digit stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] digit_char, [7] zero
    output logic        m_tlast
);

    brd_pkg::dp_cmd_t              cmd;
    brd_pkg::dp_status_t           status;
    logic [brd_pkg::RadixW-1:0]    radix_reg, radix_next;
    logic [brd_pkg::CharW-1:0]     digit_char;
    logic                          cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        radix_next = radix_reg;
        if (cfg_write && (paddr[2] == brd_pkg::RegRadix)) begin
            radix_next = pwdata[brd_pkg::RadixW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= brd_pkg::RadixReset;
        end else begin
            radix_reg <= radix_next;
        end
    end

    assign prdata = (paddr[2] == brd_pkg::RegRadix) ? 32'(radix_reg) : 32'd0;

    brd_ctrl #(
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    brd_dpath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .aclk           (aclk),
        .cmd            (cmd),
        .status         (status),
        .radix          (radix_reg),
        .value_in       (s_tdata[63:0]),
        .min_digits_in  (s_tdata[70:64]),
        .digit_char_out (digit_char),
        .last_out       (m_tlast)
    );

    assign m_tdata = {1'b0, digit_char};

endmodule
